// ===== src/gct_pkg.sv =====
// ============================================================================
// gct_pkg: shared constants for the grid cell tessellator
// Default parameter values, configuration width, queue depth and the width
// of the packed job bundle passed from the front end to the back end.
// ============================================================================
package gct_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int INDEX_BITS_DEF   = 20;
  localparam int CFG_BITS         = 11;
  localparam int GRID_WIDTH_RESET = 1024;
  localparam int QUEUE_DEPTH      = 2;

  // One job holds five cells (point, E, S, SE, SW) and a run flag; a bundle
  // holds the two jobs that one beat can cause.
  function automatic int bundle_bits(input int index_bits);
    return 2 * (5 * (index_bits + 2) + 1);
  endfunction

endpackage

// ===== src/gct_queue.sv =====
// ============================================================================
// gct_queue: short job queue between front end and back end
// A small register FIFO that lets the front end and the back end stall
// independently of each other.
// ============================================================================
module gct_queue #(
  parameter int WIDTH = gct_pkg::bundle_bits(gct_pkg::INDEX_BITS_DEF),
  parameter int DEPTH = gct_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import gct_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count_r != NW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + NW'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH))
    else $error("queue count exceeds depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push_fire && !pop_fire |=> count_r == $past(count_r) + NW'(1))
    else $error("queue count did not follow a push");

endmodule

// ===== src/gct_front.sv =====
// ============================================================================
// gct_front: beat intake, line buffer and job building
// Tracks column and first row, keeps the row below in a line buffer memory,
// holds one cell back for its east neighbor and builds the jobs of a beat.
// ============================================================================
module gct_front #(
  parameter int MAX_WIDTH  = gct_pkg::MAX_WIDTH_DEF,
  parameter int INDEX_BITS = gct_pkg::INDEX_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         cfg_wr_en,
  input  logic [gct_pkg::CFG_BITS-1:0]                 cfg_wr_data,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic                                         in_start_of_grid,
  input  logic                                         in_occupied,
  input  logic                                         in_is_hull,
  input  logic [INDEX_BITS-1:0]                        in_point_index,
  output logic                                         push_valid,
  input  logic                                         push_ready,
  output logic [gct_pkg::bundle_bits(INDEX_BITS)-1:0]  push_data
);
  import gct_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int CW      = WW + 1;
  localparam int RESET_W = (GRID_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_WIDTH_RESET;

  typedef struct packed {
    logic                  occ;
    logic                  hull;
    logic [INDEX_BITS-1:0] idx;
  } cell_t;

  typedef struct packed {
    cell_t p;
    cell_t e;
    cell_t s;
    cell_t se;
    cell_t sw;
    logic  run_before;
  } job_t;

  typedef struct packed {
    job_t j1;
    job_t j2;
  } bundle_t;

  localparam cell_t EMPTY_CELL = '0;

  cell_t         mem [MAX_WIDTH];
  cell_t         rdata_r;

  logic [WW-1:0] w_r, w_nxt;
  logic [AW-1:0] column_r, column_nxt;
  logic          first_row_r, first_row_nxt;
  logic          b_vld_r;

  cell_t         b_cell_r;
  logic          b_col_nz_r;
  logic          b_eor_r;
  logic          b_first_r;
  logic          b_se_ok_r;

  cell_t         held_cell_r;
  cell_t         held_s_r;
  cell_t         held_sw_r;
  logic          held_hasw_r;
  logic          held_run_r;

  logic [31:0]   cfg_ext;
  cell_t         in_cell;
  logic          need_restore;
  logic          in_fire;
  logic          restore_go;
  logic          push_fire;
  logic [AW-1:0] col_eff;
  logic          first_eff;
  logic          eor;
  logic          se_ok;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  cell_t         mem_wdata;
  bundle_t       bundle;

  always_comb begin
    cfg_ext = 32'(cfg_wr_data);
    if (cfg_ext == 32'd0) begin
      w_nxt = WW'(1);
    end else if (cfg_ext > 32'(MAX_WIDTH)) begin
      w_nxt = WW'(MAX_WIDTH);
    end else begin
      w_nxt = WW'(cfg_ext);
    end
  end

  assign in_cell      = '{occ: in_occupied, hull: in_is_hull, idx: in_point_index};
  assign need_restore = in_start_of_grid && (column_r != '0);
  assign in_ready     = !need_restore && (!b_vld_r || push_ready);
  assign in_fire      = in_valid && in_ready;
  assign restore_go   = in_valid && need_restore && !b_vld_r;
  assign push_valid   = b_vld_r;
  assign push_fire    = b_vld_r && push_ready;

  assign col_eff   = in_start_of_grid ? '0 : column_r;
  assign first_eff = in_start_of_grid || first_row_r;
  assign eor       = (CW'(col_eff) + CW'(1)) >= CW'(w_r);
  assign se_ok     = CW'(col_eff) < CW'(w_r);

  assign column_nxt    = eor ? '0 : col_eff + AW'(1);
  assign first_row_nxt = eor ? 1'b0 : first_eff;

  // A held cell dropped by a new grid gets its old line buffer entry back.
  assign mem_we    = in_fire || restore_go;
  assign mem_addr  = restore_go ? column_r - AW'(1) : col_eff;
  assign mem_wdata = restore_go ? held_s_r : in_cell;

  always_comb begin
    bundle = '0;
    if (b_col_nz_r) begin
      bundle.j1.p          = held_cell_r;
      bundle.j1.e          = b_cell_r;
      bundle.j1.s          = b_first_r ? EMPTY_CELL : held_s_r;
      bundle.j1.se         = (b_first_r || !b_se_ok_r) ? EMPTY_CELL : rdata_r;
      bundle.j1.sw         = (b_first_r || !held_hasw_r) ? EMPTY_CELL : held_sw_r;
      bundle.j1.run_before = held_run_r;
    end
    if (b_eor_r) begin
      bundle.j2.p          = b_cell_r;
      bundle.j2.e          = EMPTY_CELL;
      bundle.j2.s          = b_first_r ? EMPTY_CELL : rdata_r;
      bundle.j2.se         = EMPTY_CELL;
      bundle.j2.sw         = (b_first_r || !b_col_nz_r) ? EMPTY_CELL : held_s_r;
      bundle.j2.run_before = b_col_nz_r && held_cell_r.occ;
    end
  end

  assign push_data = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= WW'(RESET_W);
      column_r    <= '0;
      first_row_r <= 1'b1;
      b_vld_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        w_r <= w_nxt;
      end
      if (restore_go) begin
        column_r <= '0;
      end else if (in_fire) begin
        column_r    <= column_nxt;
        first_row_r <= first_row_nxt;
      end
      if (in_fire) begin
        b_vld_r <= 1'b1;
      end else if (push_ready) begin
        b_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_cell_r   <= in_cell;
      b_col_nz_r <= (col_eff != '0);
      b_eor_r    <= eor;
      b_first_r  <= first_eff;
      b_se_ok_r  <= se_ok;
    end
    if (push_fire && !b_eor_r) begin
      held_cell_r <= b_cell_r;
      held_s_r    <= rdata_r;
      held_sw_r   <= held_s_r;
      held_hasw_r <= b_col_nz_r;
      held_run_r  <= b_col_nz_r && held_cell_r.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (in_fire) begin
      rdata_r <= mem[mem_addr];
    end
  end

  a_restore_clears: assert property (@(posedge clk) disable iff (!rst_n)
    restore_go |=> column_r == '0)
    else $error("column not cleared after line buffer restore");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && eor |=> column_r == '0 && !first_row_r)
    else $error("row end did not restart the column");

endmodule

// ===== src/gct_back.sv =====
// ============================================================================
// gct_back: record sequencer
// Expands the queue head's jobs into spring and triangle records, one record
// per cycle unless out_ready stalls, into a registered output stage.
// ============================================================================
module gct_back #(
  parameter int INDEX_BITS = gct_pkg::INDEX_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         pop_valid,
  output logic                                         pop_ready,
  input  logic [gct_pkg::bundle_bits(INDEX_BITS)-1:0]  pop_data,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic                                         out_kind,
  output logic [INDEX_BITS-1:0]                        out_index_a,
  output logic [INDEX_BITS-1:0]                        out_index_b,
  output logic [INDEX_BITS-1:0]                        out_index_c,
  output logic [1:0]                                   out_dir_a,
  output logic [2:0]                                   out_dir_b,
  output logic                                         out_last
);
  import gct_pkg::*;

  localparam logic KIND_SPRING   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  localparam logic [2:0] SLOT_E      = 3'd0;
  localparam logic [2:0] SLOT_SE     = 3'd1;
  localparam logic [2:0] SLOT_S      = 3'd2;
  localparam logic [2:0] SLOT_SW     = 3'd3;
  localparam logic [2:0] SLOT_TRI_A  = 3'd4;
  localparam logic [2:0] SLOT_TRI_B  = 3'd5;
  localparam logic [2:0] SLOT_CORNER = 3'd6;

  typedef struct packed {
    logic                  occ;
    logic                  hull;
    logic [INDEX_BITS-1:0] idx;
  } cell_t;

  typedef struct packed {
    cell_t p;
    cell_t e;
    cell_t s;
    cell_t se;
    cell_t sw;
    logic  run_before;
  } job_t;

  typedef struct packed {
    job_t j1;
    job_t j2;
  } bundle_t;

  typedef struct packed {
    logic                  kind;
    logic [INDEX_BITS-1:0] a;
    logic [INDEX_BITS-1:0] b;
    logic [INDEX_BITS-1:0] c;
    logic [1:0]            da;
    logic [2:0]            db;
  } record_t;

  function automatic logic [6:0] job_mask(input job_t j);
    logic tri_a;
    logic tri_b;
    logic corner;
    tri_a  = (j.e.occ && j.se.occ) || (j.e.occ && j.s.occ) || (j.se.occ && j.s.occ);
    tri_b  = j.e.occ && j.se.occ && j.s.occ;
    corner = !j.run_before && j.s.occ && j.sw.occ;
    return {corner, tri_b, tri_a, j.sw.occ, j.s.occ, j.se.occ, j.e.occ} & {7{j.p.occ}};
  endfunction

  function automatic record_t job_record(input job_t j, input logic [2:0] slot);
    record_t r;
    logic    split;
    logic    quad;
    r     = '0;
    quad  = j.e.occ && j.se.occ && j.s.occ;
    split = !(j.p.hull && j.se.hull) && j.s.hull && j.e.hull;
    unique case (slot)
      SLOT_E, SLOT_SE, SLOT_S, SLOT_SW: begin
        r.kind = KIND_SPRING;
        r.a    = j.p.idx;
        r.da   = slot[1:0];
        r.db   = {1'b1, slot[1:0]};
        case (slot)
          SLOT_E:  r.b = j.e.idx;
          SLOT_SE: r.b = j.se.idx;
          SLOT_S:  r.b = j.s.idx;
          default: r.b = j.sw.idx;
        endcase
      end
      SLOT_TRI_A: begin
        r.kind = KIND_TRIANGLE;
        r.a    = j.p.idx;
        r.b    = j.e.occ ? j.e.idx : j.se.idx;
        if (quad && split) begin
          r.c = j.s.idx;
        end else if (j.e.occ && j.se.occ) begin
          r.c = j.se.idx;
        end else begin
          r.c = j.s.idx;
        end
      end
      SLOT_TRI_B: begin
        r.kind = KIND_TRIANGLE;
        if (split) begin
          r.a = j.s.idx;
          r.b = j.e.idx;
          r.c = j.se.idx;
        end else begin
          r.a = j.p.idx;
          r.b = j.se.idx;
          r.c = j.s.idx;
        end
      end
      SLOT_CORNER: begin
        r.kind = KIND_TRIANGLE;
        r.a    = j.p.idx;
        r.b    = j.s.idx;
        r.c    = j.sw.idx;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  bundle_t   head;
  logic [6:0] m1, m2, rem1, rem, rem_after, pick;
  logic [2:0] slot;
  logic       use2;
  logic       final_rec;
  logic       slot_free;
  logic       act;
  logic       emit;
  record_t    rec;

  logic       phase_r, phase_nxt;
  logic [6:0] done_r, done_nxt;
  logic       out_valid_r;
  record_t    out_rec_r;
  logic       out_last_r;

  assign head = bundle_t'(pop_data);
  assign m1   = job_mask(head.j1);
  assign m2   = job_mask(head.j2);
  assign rem1 = m1 & ~done_r;
  assign use2 = phase_r || (rem1 == '0);
  assign rem  = use2 ? (m2 & (phase_r ? ~done_r : {7{1'b1}})) : rem1;

  always_comb begin
    slot = SLOT_E;
    for (int i = 6; i >= 0; i--) begin
      if (rem[i]) begin
        slot = 3'(i);
      end
    end
  end

  assign pick      = 7'(1) << slot;
  assign rem_after = rem & ~pick;
  assign final_rec = (rem_after == '0) && (use2 || (m2 == '0));
  assign slot_free = !out_valid_r || out_ready;
  assign act       = pop_valid && slot_free;
  assign emit      = act && (rem != '0);
  assign pop_ready = slot_free && ((rem == '0) || final_rec);
  assign rec       = job_record(use2 ? head.j2 : head.j1, slot);

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = done_r;
    if (act) begin
      if ((rem == '0) || final_rec) begin
        phase_nxt = 1'b0;
        done_nxt  = '0;
      end else if (use2) begin
        phase_nxt = 1'b1;
        done_nxt  = (phase_r ? done_r : 7'd0) | pick;
      end else begin
        done_nxt = done_r | pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rec_r  <= rec;
      out_last_r <= final_rec;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_rec_r.kind;
  assign out_index_a = out_rec_r.a;
  assign out_index_b = out_rec_r.b;
  assign out_index_c = out_rec_r.c;
  assign out_dir_a   = out_rec_r.da;
  assign out_dir_b   = out_rec_r.db;
  assign out_last    = out_last_r;

  a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> $onehot(pick))
    else $error("record pick is not one-hot");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    emit && final_rec |=> !phase_r && done_r == '0)
    else $error("sequencer not rewound after the final record");

  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> pop_valid)
    else $error("second job phase without a queue head");

endmodule

// ===== src/grid_cell_tessellator.sv =====
// ============================================================================
// grid_cell_tessellator: spring and triangle records from a raster of cells
// Front end with line buffer and held cell, a job queue, and a record
// sequencer with a registered output stage.
// ============================================================================
// A beat is registered in the front end, queued and expanded into records
// in the registered output stage. The sequencer gives one record per cycle
// unless out_ready stalls it, 0 to 14 per beat; the line buffer takes one beat
// per cycle unless the queue is full or a mid-row new grid restores it first.
// Reset: synchronous, active low; clears counters, queue and output valid.
// The line buffer is not cleared; the first row of a grid never reads it.
module grid_cell_tessellator #(
  parameter int MAX_WIDTH  = gct_pkg::MAX_WIDTH_DEF,
  parameter int INDEX_BITS = gct_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [gct_pkg::CFG_BITS-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_start_of_grid,
  input  logic                         in_occupied,
  input  logic                         in_is_hull,
  input  logic [INDEX_BITS-1:0]        in_point_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [INDEX_BITS-1:0]        out_index_a,
  output logic [INDEX_BITS-1:0]        out_index_b,
  output logic [INDEX_BITS-1:0]        out_index_c,
  output logic [1:0]                   out_dir_a,
  output logic [2:0]                   out_dir_b,
  output logic                         out_last
);
  import gct_pkg::*;

  localparam int BW = bundle_bits(INDEX_BITS);

  logic          push_valid;
  logic          push_ready;
  logic [BW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [BW-1:0] pop_data;

  gct_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_of_grid (in_start_of_grid),
    .in_occupied      (in_occupied),
    .in_is_hull       (in_is_hull),
    .in_point_index   (in_point_index),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_data        (push_data)
  );

  gct_queue #(
    .WIDTH (BW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gct_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_index_a (out_index_a),
    .out_index_b (out_index_b),
    .out_index_c (out_index_c),
    .out_dir_a   (out_dir_a),
    .out_dir_b   (out_dir_b),
    .out_last    (out_last)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the grid cell tessellator
// Streams raster-ordered grid cells into the block, predicts every spring and
// triangle record with an independent model of the tessellation, and checks
// the records in order as they leave. Covers full-width rows, out-of-range
// widths, width changes in mid-row, new grids started in mid-row and random
// grids, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_W       = gct_pkg::MAX_WIDTH_DEF;
  localparam int IDX_W       = gct_pkg::INDEX_BITS_DEF;
  localparam int WDOG_LIMIT  = 4000;
  localparam int REPORT_MAX  = 10;

  localparam bit KIND_SPRING   = 1'b0;
  localparam bit KIND_TRIANGLE = 1'b1;

  localparam int DIR_E  = 0;
  localparam int DIR_SE = 1;
  localparam int DIR_S  = 2;
  localparam int DIR_SW = 3;

  typedef struct packed {
    logic             occ;
    logic             hull;
    logic [IDX_W-1:0] idx;
  } grid_cell_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic [1:0]       da;
    logic [2:0]       db;
    logic             last;
  } mesh_rec_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [gct_pkg::CFG_BITS-1:0] cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_start_of_grid = 1'b0;
  logic                         in_occupied = 1'b0;
  logic                         in_is_hull = 1'b0;
  logic [IDX_W-1:0]             in_point_index = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         out_kind;
  logic [IDX_W-1:0]             out_index_a;
  logic [IDX_W-1:0]             out_index_b;
  logic [IDX_W-1:0]             out_index_c;
  logic [1:0]                   out_dir_a;
  logic [2:0]                   out_dir_b;
  logic                         out_last;

  grid_cell_tessellator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_of_grid (in_start_of_grid),
    .in_occupied      (in_occupied),
    .in_is_hull       (in_is_hull),
    .in_point_index   (in_point_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_index_a      (out_index_a),
    .out_index_b      (out_index_b),
    .out_index_c      (out_index_c),
    .out_dir_a        (out_dir_a),
    .out_dir_b        (out_dir_b),
    .out_last         (out_last)
  );

  always #4 clk = ~clk;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // Tessellation state mirrored from the block.
  grid_cell_t                   below_row [MAX_W];
  grid_cell_t                   held_cell = '0;
  grid_cell_t                   below_west = '0;
  bit                           run_flag = 1'b0;
  bit                           bottom_row = 1'b1;
  int unsigned                  next_col = 0;
  logic [gct_pkg::CFG_BITS-1:0] width_reg = gct_pkg::GRID_WIDTH_RESET;

  mesh_rec_t beat_records[$];
  mesh_rec_t mesh_records[$];

  task automatic add_record(input bit kind, input logic [IDX_W-1:0] a, b, c,
                            input int da, input int db);
    mesh_rec_t r;
    r.kind = kind;
    r.a    = a;
    r.b    = b;
    r.c    = c;
    r.da   = da[1:0];
    r.db   = db[2:0];
    r.last = 1'b0;
    beat_records.push_back(r);
  endtask

  task automatic tessellate_cell(input grid_cell_t p, input int unsigned h,
                                 input grid_cell_t e, input int unsigned w);
    grid_cell_t s, se, sw;
    grid_cell_t nb [4];
    bit run_before, p_se, s_e;
    s = '0;
    se = '0;
    sw = '0;
    run_before = run_flag;
    if (!bottom_row) begin
      s = below_row[h];
      if (h + 1 < w) se = below_row[h + 1];
      if (h > 0) sw = below_west;
    end
    below_west = below_row[h];
    below_row[h] = p;
    run_flag = p.occ;
    if (!p.occ) return;

    nb[DIR_E] = e;
    nb[DIR_SE] = se;
    nb[DIR_S] = s;
    nb[DIR_SW] = sw;
    for (int i = DIR_E; i <= DIR_SW; i++) begin
      if (nb[i].occ) add_record(KIND_SPRING, p.idx, nb[i].idx, '0, i, (i + 4) % 8);
    end

    if (e.occ) begin
      if (se.occ) begin
        if (s.occ) begin
          p_se = p.hull && se.hull;
          s_e = s.hull && e.hull;
          if (!p_se && s_e) begin
            add_record(KIND_TRIANGLE, p.idx, e.idx, s.idx, 0, 0);
            add_record(KIND_TRIANGLE, s.idx, e.idx, se.idx, 0, 0);
          end else begin
            add_record(KIND_TRIANGLE, p.idx, e.idx, se.idx, 0, 0);
            add_record(KIND_TRIANGLE, p.idx, se.idx, s.idx, 0, 0);
          end
        end else begin
          add_record(KIND_TRIANGLE, p.idx, e.idx, se.idx, 0, 0);
        end
      end else if (s.occ) begin
        add_record(KIND_TRIANGLE, p.idx, e.idx, s.idx, 0, 0);
      end
    end else if (se.occ && s.occ) begin
      add_record(KIND_TRIANGLE, p.idx, se.idx, s.idx, 0, 0);
    end

    if (!run_before && s.occ && sw.occ)
      add_record(KIND_TRIANGLE, p.idx, s.idx, sw.idx, 0, 0);
  endtask

  task automatic predict_beat(input bit sog, occ, hull, input logic [IDX_W-1:0] idx);
    int unsigned w;
    grid_cell_t c;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    c = {occ, hull, idx};
    beat_records.delete();
    if (sog) begin
      held_cell = '0;
      run_flag = 1'b0;
      next_col = 0;
      bottom_row = 1'b1;
      below_west = '0;
    end
    if (next_col > 0) tessellate_cell(held_cell, next_col - 1, c, w);
    held_cell = c;
    if (next_col + 1 >= w) begin
      tessellate_cell(held_cell, next_col, '0, w);
      held_cell = '0;
      next_col = 0;
      bottom_row = 1'b0;
      run_flag = 1'b0;
      below_west = '0;
    end else begin
      next_col++;
    end
    if (beat_records.size() > 0) beat_records[beat_records.size() - 1].last = 1'b1;
    foreach (beat_records[i]) mesh_records.push_back(beat_records[i]);
  endtask

  task automatic send_cell(input bit sog, occ, hull, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_of_grid <= sog;
    in_occupied <= occ;
    in_is_hull <= hull;
    in_point_index <= idx;
    do @(posedge clk); while (!in_ready);
    predict_beat(sog, occ, hull, idx);
  endtask

  task automatic wait_mesh_idle();
    in_valid <= 1'b0;
    while (mesh_records.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_width(input logic [gct_pkg::CFG_BITS-1:0] w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = w;
  endtask

  task automatic report_mismatch(input string what, input mesh_rec_t e, g);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%s: expected kind=%0d a=%h b=%h c=%h dir=%0d/%0d last=%0d, got kind=%0d a=%h b=%h c=%h dir=%0d/%0d last=%0d",
               what, e.kind, e.a, e.b, e.c, e.da, e.db, e.last,
               g.kind, g.a, g.b, g.c, g.da, g.db, g.last);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_records
    mesh_rec_t want, got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_kind, out_index_a, out_index_b, out_index_c, out_dir_a, out_dir_b, out_last};
      if (mesh_records.size() == 0) begin
        report_mismatch("unexpected record", '0, got);
      end else begin
        want = mesh_records.pop_front();
        if (got !== want) report_mismatch("record mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // The reset width covers the whole line buffer, so no later row reads an
  // entry that was never written.
  task automatic test_full_width_rows();
    for (int k = 0; k < MAX_W + 6; k++)
      send_cell(k == 0, $urandom_range(99) < 60, $urandom_range(1), $urandom_range(20'hFFFFF));
    wait_mesh_idle();
  endtask

  task automatic test_directed_cells();
    set_width(3);
    send_cell(1, 1, 1, 20'h00000);
    send_cell(0, 1, 1, 20'hFFFFF);
    send_cell(0, 1, 0, 20'h00003);
    // The first cell of this row has a hull S-E diagonal and a soft P-SE one.
    send_cell(0, 1, 0, 20'h00010);
    send_cell(0, 1, 1, 20'h00011);
    send_cell(0, 0, 1, 20'h12345);
    send_cell(0, 1, 1, 20'h00020);
    send_cell(0, 1, 1, 20'h00021);
    send_cell(0, 1, 0, 20'h00022);
    // A run starting after an empty cell gets the P-S-SW corner.
    send_cell(0, 0, 0, 20'h00000);
    send_cell(0, 1, 0, 20'h00031);
    send_cell(0, 1, 1, 20'h00032);
    send_cell(0, 1, 0, 20'h00040);
    // A new grid in mid-row drops the held cell.
    send_cell(1, 1, 1, 20'h00050);
    send_cell(0, 1, 0, 20'h00051);
    send_cell(0, 1, 1, 20'h00052);
    send_cell(0, 1, 1, 20'h00060);
    send_cell(0, 1, 0, 20'h00061);
    wait_mesh_idle();
    // Shrinking below the current column ends the row at the next cell.
    set_width(2);
    send_cell(0, 1, 1, 20'h00062);
    send_cell(0, 1, 0, 20'h00070);
    send_cell(0, 1, 1, 20'h00071);
    send_cell(0, 1, 1, 20'h00080);
    wait_mesh_idle();
    set_width(5);
    send_cell(0, 1, 0, 20'h00081);
    send_cell(0, 1, 1, 20'h00082);
    send_cell(0, 1, 1, 20'hFFFFF);
    wait_mesh_idle();
  endtask

  task automatic test_width_limits();
    set_width(0);
    send_cell(1, 1, 1, $urandom_range(20'hFFFFF));
    for (int k = 0; k < 5; k++)
      send_cell(k == 3, $urandom_range(1), $urandom_range(1), $urandom_range(20'hFFFFF));
    wait_mesh_idle();
    set_width(1);
    for (int k = 0; k < 5; k++)
      send_cell(k == 0, 1, $urandom_range(1), $urandom_range(20'hFFFFF));
    wait_mesh_idle();
    set_width('1);
    for (int k = 0; k < MAX_W + 3; k++)
      send_cell(k == 0, $urandom_range(99) < 25, $urandom_range(1), $urandom_range(20'hFFFFF));
    wait_mesh_idle();
  endtask

  task automatic test_random_grids(input int n_items);
    int sent, w, rows, cells, occ_pct, sel;
    sent = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(1) == 1) begin
        sel = $urandom_range(99);
        if (sel < 3) w = 0;
        else if (sel < 80) w = $urandom_range(8, 1);
        else if (sel < 95) w = $urandom_range(40, 9);
        else w = $urandom_range(100, 41);
        wait_mesh_idle();
        set_width(w);
      end
      w = (width_reg == 0) ? 1 : width_reg;
      rows = (w > 8) ? $urandom_range(2, 1) : $urandom_range(6, 1);
      cells = w * rows;
      if ($urandom_range(4) == 0) cells = $urandom_range(cells, 1);
      if (cells > n_items - sent) cells = n_items - sent;
      occ_pct = $urandom_range(95, 30);
      for (int k = 0; k < cells; k++) begin
        if ($urandom_range(19) == 0)
          send_cell($urandom_range(1), $urandom_range(1), $urandom_range(1),
                    $urandom_range(20'hFFFFF));
        else
          send_cell(k == 0 || $urandom_range(49) == 0, $urandom_range(99) < occ_pct,
                    $urandom_range(1), $urandom_range(20'hFFFFF));
        sent++;
      end
    end
    wait_mesh_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 65;
    test_full_width_rows();
    test_directed_cells();

    send_idle_pct = 65;
    recv_idle_pct = 9;
    test_width_limits();
    test_random_grids(180);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_grids(180);

    wait_mesh_idle();
    repeat (16) @(posedge clk);
    mismatch_count += mesh_records.size();
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/gct_pkg.sv
src/gct_queue.sv
src/gct_front.sv
src/gct_back.sv
src/grid_cell_tessellator.sv
sim/testbench.sv
